// ===== hdl/ffha_pkg.sv =====
package ffha_pkg;

    localparam int BLOCKS       = 64;
    localparam int HEADER_BYTES = 32;
    localparam int IDX_W        = $clog2(BLOCKS);
    localparam int CNT_W        = $clog2(BLOCKS + 1);
    localparam int DATA_W       = 32;
    localparam int REG_IDX_W    = 1;

    localparam logic [DATA_W-1:0] HEAP_BASE_RESET = 32'd0;
    localparam logic [DATA_W-1:0] HEAP_SIZE_RESET = 32'd65536;

    localparam logic [REG_IDX_W-1:0] REG_HEAP_BASE = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HEAP_SIZE = 1'b1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_FIT    = 2'd1;
    localparam logic [1:0] ST_NOT_ALLOC = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] start;
        logic [DATA_W-1:0] length;
        logic              taken;
    } entry_t;

    typedef struct packed {
        logic              command;
        logic [DATA_W-1:0] request_size;
        logic [DATA_W-1:0] release_address;
    } request_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [DATA_W-1:0] granted_address;
        logic              nothing_allocated;
    } result_t;

endpackage

// ===== hdl/ffha_table.sv =====
module ffha_table
    import ffha_pkg::*;
(
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  entry_t           wdata,
    input  logic [IDX_W-1:0] raddr,
    output entry_t           rdata
);

    entry_t mem [BLOCKS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/first_fit_heap_allocator_unit.sv =====
// Channel   Handshake           Payload
// command   start / busy        request  (command, request_size, release_address)
// result    done (one cycle)    result   (status, granted_address, nothing_allocated)
// config    write_enable        reg_index, write_data
//
// An item reads the table entries one at a time until it finds a hit or reaches
// the last entry; a split or merge then shifts the entries behind the hit one at
// a time through the block table memory, and done rises in the same cycle that
// busy falls.
// Reset and any register write rebuild the table as one free block; entry zero is
// written lazily when the next item starts. The receiver cannot stall: done is
// high for exactly one cycle per item.
module first_fit_heap_allocator_unit
    import ffha_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  request_t             request,
    output logic                 done,
    output result_t              result,
    input  logic                 write_enable,
    input  logic [REG_IDX_W-1:0] reg_index,
    input  logic [DATA_W-1:0]    write_data
);

    localparam logic [DATA_W-1:0] HDR = DATA_W'(HEADER_BYTES);
    localparam logic [CNT_W-1:0] ONE = CNT_W'(1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(BLOCKS);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT0, S_SCAN_RD, S_SCAN_CHK, S_NEXT_RD, S_NEXT_CHK,
        S_MERGE, S_MOVE_RD, S_MOVE_WR, S_FIN_WR, S_SPLIT_WR, S_DONE
    } state_t;

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic [DATA_W-1:0] base_reg, base_next, size_reg, size_next;
    logic              pending_reg, pending_next;
    logic [CNT_W-1:0]  count_reg, count_next, tcount_reg, tcount_next;
    logic [CNT_W-1:0]  i_reg, i_next, src_reg, src_next, dst_reg, dst_next;
    logic [CNT_W-1:0]  end_reg, end_next;
    logic              up_reg, up_next;
    entry_t            hit_reg, hit_next, prev_reg, prev_next, nxt_reg, nxt_next;
    logic [1:0]        status_reg, status_next;
    logic [DATA_W-1:0] granted_reg, granted_next;
    logic              done_reg, done_next;
    result_t           result_reg, result_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    entry_t           mem_wdata, mem_rdata;

    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] sum_next, merged_len;
    logic              n_free, p_free;
    logic [CNT_W-1:0]  drop;

    ffha_table u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        rem        = mem_rdata.length - req_reg.request_size;
        n_free     = !nxt_reg.taken;
        p_free     = (i_reg != '0) && !prev_reg.taken;
        sum_next   = hit_reg.length + (n_free ? (nxt_reg.length + HDR) : '0);
        merged_len = p_free ? (prev_reg.length + HDR + sum_next) : sum_next;
        drop       = CNT_W'(n_free) + CNT_W'(p_free);
    end

    always_comb
    begin
        state_next   = state_reg;
        req_next     = req_reg;
        base_next    = base_reg;
        size_next    = size_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        tcount_next  = tcount_reg;
        i_next       = i_reg;
        src_next     = src_reg;
        dst_next     = dst_reg;
        end_next     = end_reg;
        up_next      = up_reg;
        hit_next     = hit_reg;
        prev_next    = prev_reg;
        nxt_next     = nxt_reg;
        status_next  = status_reg;
        granted_next = granted_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        mem_we       = 1'b0;
        mem_waddr    = i_reg[IDX_W-1:0];
        mem_wdata    = hit_reg;
        mem_raddr    = i_reg[IDX_W-1:0];

        if (write_enable)
        begin
            unique case (reg_index)
                REG_HEAP_BASE: base_next = write_data;
                REG_HEAP_SIZE: size_next = write_data;
                default:       ;
            endcase
            pending_next = 1'b1;
            count_next   = ONE;
            tcount_next  = '0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next     = request;
                    i_next       = '0;
                    status_next  = ST_OK;
                    granted_next = '0;
                    state_next   = pending_reg ? S_INIT0 : S_SCAN_RD;
                end
            end
            S_INIT0:
            begin
                mem_we          = 1'b1;
                mem_waddr       = '0;
                mem_wdata.start = base_reg + HDR;
                mem_wdata.length = size_reg;
                mem_wdata.taken = 1'b0;
                pending_next    = 1'b0;
                state_next      = S_SCAN_RD;
            end
            S_SCAN_RD:
            begin
                if (i_reg == count_reg)
                begin
                    status_next = (req_reg.command == CMD_FREE) ? ST_NOT_ALLOC : ST_NO_FIT;
                    state_next  = S_DONE;
                end
                else
                begin
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                if (req_reg.command == CMD_ALLOC)
                begin
                    if (!mem_rdata.taken && mem_rdata.length >= req_reg.request_size)
                    begin
                        hit_next     = mem_rdata;
                        tcount_next  = tcount_reg + ONE;
                        granted_next = mem_rdata.start;
                        if (rem != '0 && rem >= HDR && count_reg < FULL)
                        begin
                            src_next   = count_reg - ONE;
                            dst_next   = count_reg;
                            end_next   = i_reg + ONE;
                            up_next    = 1'b0;
                            count_next = count_reg + ONE;
                            state_next = S_MOVE_RD;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_wdata       = mem_rdata;
                            mem_wdata.taken = 1'b1;
                            state_next      = S_DONE;
                        end
                    end
                    else
                    begin
                        prev_next  = mem_rdata;
                        i_next     = i_reg + ONE;
                        state_next = S_SCAN_RD;
                    end
                end
                else
                begin
                    if (mem_rdata.taken && mem_rdata.start == req_reg.release_address)
                    begin
                        hit_next       = mem_rdata;
                        tcount_next    = tcount_reg - ONE;
                        nxt_next       = mem_rdata;
                        // Without a successor the merge sees a taken neighbor.
                        nxt_next.taken = 1'b1;
                        state_next     = (i_reg + ONE < count_reg) ? S_NEXT_RD : S_MERGE;
                    end
                    else
                    begin
                        prev_next  = mem_rdata;
                        i_next     = i_reg + ONE;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_NEXT_RD:
            begin
                mem_raddr  = IDX_W'(i_reg + ONE);
                state_next = S_NEXT_CHK;
            end
            S_NEXT_CHK:
            begin
                nxt_next   = mem_rdata;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                mem_we           = 1'b1;
                mem_waddr        = IDX_W'(p_free ? (i_reg - ONE) : i_reg);
                mem_wdata.start  = p_free ? prev_reg.start : hit_reg.start;
                mem_wdata.length = merged_len;
                mem_wdata.taken  = 1'b0;
                src_next         = i_reg + ONE + CNT_W'(n_free);
                dst_next         = i_reg + ONE + CNT_W'(n_free) - drop;
                end_next         = count_reg;
                up_next          = 1'b1;
                count_next       = count_reg - drop;
                state_next       = S_MOVE_RD;
            end
            S_MOVE_RD:
            begin
                mem_raddr = src_reg[IDX_W-1:0];
                if (up_reg ? (src_reg == end_reg) : (src_reg < end_reg))
                begin
                    state_next = up_reg ? S_DONE : S_FIN_WR;
                end
                else
                begin
                    state_next = S_MOVE_WR;
                end
            end
            S_MOVE_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = dst_reg[IDX_W-1:0];
                mem_wdata  = mem_rdata;
                src_next   = up_reg ? (src_reg + ONE) : (src_reg - ONE);
                dst_next   = up_reg ? (dst_reg + ONE) : (dst_reg - ONE);
                state_next = S_MOVE_RD;
            end
            S_FIN_WR:
            begin
                mem_we           = 1'b1;
                mem_wdata.start  = hit_reg.start;
                mem_wdata.length = req_reg.request_size;
                mem_wdata.taken  = 1'b1;
                state_next       = S_SPLIT_WR;
            end
            S_SPLIT_WR:
            begin
                mem_we           = 1'b1;
                mem_waddr        = IDX_W'(i_reg + ONE);
                mem_wdata.start  = hit_reg.start + req_reg.request_size + HDR;
                mem_wdata.length = hit_reg.length - req_reg.request_size - HDR;
                mem_wdata.taken  = 1'b0;
                state_next       = S_DONE;
            end
            S_DONE:
            begin
                done_next                     = 1'b1;
                result_next.status            = status_reg;
                result_next.granted_address   = granted_reg;
                result_next.nothing_allocated = (tcount_reg == '0);
                state_next                    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            base_reg    <= HEAP_BASE_RESET;
            size_reg    <= HEAP_SIZE_RESET;
            pending_reg <= 1'b1;
            count_reg   <= ONE;
            tcount_reg  <= '0;
            done_reg    <= 1'b0;
            req_reg     <= '0;
            i_reg       <= '0;
            src_reg     <= '0;
            dst_reg     <= '0;
            end_reg     <= '0;
            up_reg      <= 1'b0;
            hit_reg     <= '0;
            prev_reg    <= '0;
            nxt_reg     <= '0;
            status_reg  <= ST_OK;
            granted_reg <= '0;
            result_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            base_reg    <= base_next;
            size_reg    <= size_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            tcount_reg  <= tcount_next;
            done_reg    <= done_next;
            req_reg     <= req_next;
            i_reg       <= i_next;
            src_reg     <= src_next;
            dst_reg     <= dst_next;
            end_reg     <= end_next;
            up_reg      <= up_next;
            hit_reg     <= hit_next;
            prev_reg    <= prev_next;
            nxt_reg     <= nxt_next;
            status_reg  <= status_next;
            granted_reg <= granted_next;
            result_reg  <= result_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTH
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= FULL)
        else $error("block count out of range");

    a_taken_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        tcount_reg <= count_reg)
        else $error("more taken blocks than blocks");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held for more than one cycle");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");
`endif

endmodule

// ===== sim/testbench.sv =====
module testbench;
    import ffha_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    request_t             request;
    logic                 done;
    result_t              result;
    logic                 write_enable;
    logic [REG_IDX_W-1:0] reg_index;
    logic [DATA_W-1:0]    write_data;

    first_fit_heap_allocator_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .request      (request),
        .done         (done),
        .result       (result),
        .write_enable (write_enable),
        .reg_index    (reg_index),
        .write_data   (write_data)
    );

    // Predicted copy of the block table and its registers.
    logic [DATA_W-1:0] heap_base_q;
    logic [DATA_W-1:0] heap_size_q;
    logic [DATA_W-1:0] blk_start  [BLOCKS];
    logic [DATA_W-1:0] blk_length [BLOCKS];
    logic              blk_valid  [BLOCKS];
    logic              blk_taken  [BLOCKS];

    result_t pending_results[$];
    int      error_count;
    int      items_sent;

    // Directed rows; a row with has_golden set also carries a typed-in result.
    typedef struct {
        logic     command;
        logic [31:0] size_or_addr;
        logic     has_golden;
        result_t  golden;
    } directed_row_t;

    directed_row_t directed_rows[$];

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    function automatic void rebuild_table();
        for (int i = 0; i < BLOCKS; i++)
        begin
            blk_start[i]  = '0;
            blk_length[i] = '0;
            blk_valid[i]  = 1'b0;
            blk_taken[i]  = 1'b0;
        end
        blk_start[0]  = heap_base_q + HEADER_BYTES;
        blk_length[0] = heap_size_q;
        blk_valid[0]  = 1'b1;
    endfunction

    function automatic int blocks_in_use();
        int n;
        n = 0;
        while (n < BLOCKS && blk_valid[n])
            n++;
        return n;
    endfunction

    function automatic void open_slot(int p, int count);
        for (int i = count; i > p; i--)
        begin
            blk_start[i]  = blk_start[i-1];
            blk_length[i] = blk_length[i-1];
            blk_valid[i]  = blk_valid[i-1];
            blk_taken[i]  = blk_taken[i-1];
        end
    endfunction

    function automatic void close_slot(int p, int count);
        for (int i = p; i + 1 < count; i++)
        begin
            blk_start[i]  = blk_start[i+1];
            blk_length[i] = blk_length[i+1];
            blk_valid[i]  = blk_valid[i+1];
            blk_taken[i]  = blk_taken[i+1];
        end
        blk_start[count-1]  = '0;
        blk_length[count-1] = '0;
        blk_valid[count-1]  = 1'b0;
        blk_taken[count-1]  = 1'b0;
    endfunction

    function automatic result_t allocate_or_free(request_t req);
        result_t r;
        int count;
        int hit;
        logic [DATA_W-1:0] rem;
        r = '0;
        count = blocks_in_use();
        hit = -1;
        if (req.command == CMD_ALLOC)
        begin
            for (int i = 0; i < count; i++)
                if (hit < 0 && !blk_taken[i] && blk_length[i] >= req.request_size)
                    hit = i;
            if (hit < 0)
                r.status = ST_NO_FIT;
            else
            begin
                rem = blk_length[hit] - req.request_size;
                blk_taken[hit] = 1'b1;
                r.granted_address = blk_start[hit];
                if (rem >= HEADER_BYTES && rem != 0 && count < BLOCKS)
                begin
                    blk_length[hit] = req.request_size;
                    open_slot(hit + 1, count);
                    blk_start[hit+1]  = blk_start[hit] + req.request_size + HEADER_BYTES;
                    blk_length[hit+1] = rem - HEADER_BYTES;
                    blk_valid[hit+1]  = 1'b1;
                    blk_taken[hit+1]  = 1'b0;
                end
            end
        end
        else
        begin
            for (int i = 0; i < count; i++)
                if (hit < 0 && blk_taken[i] && blk_start[i] == req.release_address)
                    hit = i;
            if (hit < 0)
                r.status = ST_NOT_ALLOC;
            else
            begin
                blk_taken[hit] = 1'b0;
                if (hit + 1 < count && !blk_taken[hit+1])
                begin
                    blk_length[hit] += blk_length[hit+1] + HEADER_BYTES;
                    close_slot(hit + 1, count);
                    count--;
                end
                if (hit > 0 && !blk_taken[hit-1])
                begin
                    blk_length[hit-1] += blk_length[hit] + HEADER_BYTES;
                    close_slot(hit, count);
                end
            end
        end
        r.nothing_allocated = 1'b1;
        for (int i = 0; i < BLOCKS; i++)
            if (blk_valid[i] && blk_taken[i])
                r.nothing_allocated = 1'b0;
        return r;
    endfunction

    // Pick an allocated start address at random, or a random word if none.
    function automatic logic [31:0] some_taken_address();
        int picks[$];
        for (int i = 0; i < BLOCKS; i++)
            if (blk_valid[i] && blk_taken[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return $urandom;
        return blk_start[picks[$urandom_range(0, picks.size() - 1)]];
    endfunction

    task automatic idle_gap();
        int n;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: n = 1;
            4, 5, 6, 7, 8: n = $urandom_range(1, 3);
            default: n = $urandom_range(10, 300);
        endcase
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        while (pending_results.size() != 0)
            @(posedge clk);
        // Let the block return to idle before any register write.
        repeat (4 * BLOCKS + 16) @(posedge clk);
    endtask

    task automatic write_register(logic [REG_IDX_W-1:0] idx, logic [31:0] value);
        write_enable <= 1'b1;
        reg_index    <= idx;
        write_data   <= value;
        @(posedge clk);
        write_enable <= 1'b0;
        if (idx == REG_HEAP_BASE)
            heap_base_q = value;
        else
            heap_size_q = value;
        rebuild_table();
        @(posedge clk);
    endtask

    // Drive one item and hold start until it is taken.
    task automatic send_item(request_t req, logic has_golden, result_t golden);
        result_t predicted;
        start   <= 1'b1;
        request <= req;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = allocate_or_free(req);
        if (has_golden && predicted !== golden)
            $display("%0t directed row predicted %p, typed-in %p", $realtime, predicted, golden);
        pending_results.push_back(has_golden ? golden : predicted);
        items_sent++;
        start <= 1'b0;
        idle_gap();
    endtask

    function automatic request_t random_request(int heap_bytes);
        request_t req;
        req = '0;
        req.command = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
        req.request_size = $urandom;
        req.release_address = $urandom;
        if (req.command == CMD_ALLOC)
        begin
            case ($urandom_range(0, 9))
                0: req.request_size = $urandom;
                1: req.request_size = $urandom_range(0, 40);
                default: req.request_size = $urandom_range(0, heap_bytes / 8);
            endcase
        end
        else if ($urandom_range(0, 9) < 8)
            req.release_address = some_taken_address();
        return req;
    endfunction

    function automatic directed_row_t row(logic cmd, logic [31:0] v, logic g = 0,
                                          result_t gr = '0);
        directed_row_t d;
        d.command = cmd;
        d.size_or_addr = v;
        d.has_golden = g;
        d.golden = gr;
        return d;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t result with none expected: actual %p", $realtime, result);
                error_count++;
            end
            else
            begin
                result_t want;
                want = pending_results.pop_front();
                if (result.status !== want.status
                    || result.granted_address !== want.granted_address
                    || result.nothing_allocated !== want.nothing_allocated)
                begin
                    $display("%0t mismatch: expected %p, actual %p", $realtime, want, result);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #50ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        request_t req;
        int heap_bytes;
        logic [31:0] bases [4];
        logic [31:0] sizes [4];
        error_count  = 0;
        items_sent   = 0;
        rst_n        = 1'b0;
        start        = 1'b0;
        request      = '0;
        write_enable = 1'b0;
        reg_index    = REG_HEAP_BASE;
        write_data   = '0;
        heap_base_q  = HEAP_BASE_RESET;
        heap_size_q  = HEAP_SIZE_RESET;
        rebuild_table();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // After reset: one free block at 32 with 65536 bytes.
        directed_rows.push_back(row(CMD_FREE, 32'd32, 1, '{ST_NOT_ALLOC, 32'd0, 1'b1}));
        directed_rows.push_back(row(CMD_ALLOC, 32'hFFFF_FFFF, 1, '{ST_NO_FIT, 32'd0, 1'b1}));
        directed_rows.push_back(row(CMD_ALLOC, 32'd0, 1, '{ST_OK, 32'd32, 1'b0}));
        directed_rows.push_back(row(CMD_ALLOC, 32'd100, 1, '{ST_OK, 32'd64, 1'b0}));
        directed_rows.push_back(row(CMD_ALLOC, 32'd200));
        directed_rows.push_back(row(CMD_FREE, 32'd64));
        directed_rows.push_back(row(CMD_FREE, 32'd32));
        directed_rows.push_back(row(CMD_ALLOC, 32'd50));
        directed_rows.push_back(row(CMD_FREE, 32'hFFFF_FFFF, 1, '{ST_NOT_ALLOC, 32'd0, 1'b0}));
        directed_rows.push_back(row(CMD_FREE, 32'd196));
        directed_rows.push_back(row(CMD_FREE, 32'd32, 1, '{ST_OK, 32'd0, 1'b1}));
        directed_rows.push_back(row(CMD_ALLOC, 32'd65536 - 32));  // remainder equals header
        directed_rows.push_back(row(CMD_ALLOC, 32'd0));           // zero request, zero block
        directed_rows.push_back(row(CMD_FREE, 32'd32));
        directed_rows.push_back(row(CMD_ALLOC, 32'd65536 - 20));  // no free block large enough
        directed_rows.push_back(row(CMD_ALLOC, 32'd1));
        directed_rows.push_back(row(CMD_FREE, 32'd32));
        directed_rows.push_back(row(CMD_FREE, 32'd65568));
        foreach (directed_rows[k])
        begin
            req = '0;
            req.command = directed_rows[k].command;
            req.request_size = directed_rows[k].size_or_addr;
            req.release_address = directed_rows[k].size_or_addr;
            send_item(req, directed_rows[k].has_golden, directed_rows[k].golden);
        end

        // Several heap settings: wrap near the top of memory, zero size, full range.
        bases[0] = 32'hFFFF_FFF0; sizes[0] = 32'd4096;
        bases[1] = 32'h0000_1000; sizes[1] = 32'd0;
        bases[2] = 32'h8000_0000; sizes[2] = 32'hFFFF_FFFF;
        bases[3] = 32'd0;         sizes[3] = 32'd3000;
        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            if (phase < 4)
            begin
                write_register(REG_HEAP_BASE, bases[phase]);
                write_register(REG_HEAP_SIZE, sizes[phase]);
            end
            else
                write_register(REG_HEAP_SIZE, 32'd20000);
            heap_bytes = (heap_size_q > 32'd1_000_000) ? 1_000_000 : int'(heap_size_q);
            for (int n = 0; n < 130; n++)
            begin
                req = random_request(heap_bytes < 64 ? 64 : heap_bytes);
                // Runs that fill the table to its last entry.
                if (phase == 4 && n < 70)
                begin
                    req.command = CMD_ALLOC;
                    req.request_size = $urandom_range(0, 40);
                end
                send_item(req, 1'b0, '0);
            end
        end

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4 * BLOCKS + 16) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
